>>> design/ray_box_nearest_pick_top_assert.svh
// Assertion macros for the ray box nearest pick block
`ifndef RAY_BOX_NEAREST_PICK_TOP_ASSERT_SVH
`define RAY_BOX_NEAREST_PICK_TOP_ASSERT_SVH
// implication checked on every edge outside reset
`define RBNP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication checked in the following cycle
`define RBNP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> design/rbnp_pkg.sv
// Package: shared constants and types for the ray box nearest pick block
`default_nettype none
package rbnp_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int MAX_BOXES_DEF   = 1024;
    localparam int DIR_WIDTH       = 18;
    localparam int FRAC_BITS       = 16;
    localparam int IDX_WIDTH       = 10;
    localparam int T_WIDTH         = 32;
    localparam int DIST_WIDTH      = 31;
    localparam int CFG_IDX_WIDTH   = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } cfg_reg_t;

    // controller -> datapath
    typedef struct packed {
        logic       load_box;
        logic       axis_setup;
        logic       div_start;
        logic       side_hi;
        logic       axis_merge;
        logic       finish_box;
        logic       clear_best;
        logic [1:0] axis;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic dir_zero;
        logic div_done;
        logic reject;
    } dp_status_t;
endpackage
`default_nettype wire

>>> design/rbnp_ctrl.sv
// Controller: sequences the three axes per box, with up to two divisions per axis
`default_nettype none
module rbnp_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire                  last_in,
    output logic                 m_valid,
    input  wire                  m_ready,
    output rbnp_pkg::dp_cmd_t    cmd,
    input  rbnp_pkg::dp_status_t status
);
    import rbnp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP, ST_DIV_START, ST_DIV_WAIT, ST_MERGE, ST_FINISH, ST_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       hi_reg, hi_next;
    logic       last_reg, last_next;

    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        hi_next    = hi_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        cmd.side_hi = hi_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_box = 1'b1;
                    last_next    = last_in;
                    axis_next    = 2'd0;
                    state_next   = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.axis_setup = 1'b1;
                hi_next = 1'b0;
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                if (status.dir_zero) begin
                    state_next = ST_MERGE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    if (hi_reg) begin
                        state_next = ST_MERGE;
                    end else begin
                        hi_next = 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_MERGE: begin
                cmd.axis_merge = 1'b1;
                if (axis_reg == 2'd2) begin
                    state_next = ST_FINISH;
                end else begin
                    axis_next = axis_reg + 2'd1;
                    state_next = ST_SETUP;
                end
            end
            ST_FINISH: begin
                cmd.finish_box = 1'b1;
                state_next = last_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (m_ready) begin
                    cmd.clear_best = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= 2'd0;
            hi_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            hi_reg    <= hi_next;
            last_reg  <= last_next;
        end
    end
endmodule
`default_nettype wire

>>> design/rbnp_div.sv
// Divider: restoring signed division, one quotient bit a cycle, saturating
`default_nettype none
module rbnp_div #(
    parameter int NUM_WIDTH = 64,
    parameter int DEN_WIDTH = 18
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         start,
    input  wire signed [NUM_WIDTH-1:0]  num,
    input  wire signed [DEN_WIDTH-1:0]  den,
    output logic                        done,
    output logic signed [rbnp_pkg::T_WIDTH-1:0] quo
);
    import rbnp_pkg::*;
    localparam int CW = $clog2(NUM_WIDTH + 1);
    localparam logic signed [T_WIDTH-1:0] TMAX = {1'b0, {(T_WIDTH-1){1'b1}}};
    localparam logic signed [T_WIDTH-1:0] TMIN = {1'b1, {(T_WIDTH-1){1'b0}}};

    logic [NUM_WIDTH-1:0] q_reg, q_next;
    logic [DEN_WIDTH:0]   r_reg, r_next;
    logic [DEN_WIDTH-1:0] d_reg, d_next;
    logic                 neg_reg, neg_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic signed [T_WIDTH-1:0] quo_reg, quo_next;
    logic [DEN_WIDTH:0]   trial;
    logic [DEN_WIDTH+1:0] sub;
    logic                 big;

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg; neg_next = neg_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        quo_next = quo_reg;
        trial = {r_reg[DEN_WIDTH-1:0], q_reg[NUM_WIDTH-1]};
        sub   = {1'b0, trial} - {2'b00, d_reg};
        big   = |q_reg[NUM_WIDTH-1:T_WIDTH-1];
        if (start) begin
            q_next   = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : num;
            d_next   = den[DEN_WIDTH-1] ? DEN_WIDTH'(-den) : den;
            neg_next = num[NUM_WIDTH-1] ^ den[DEN_WIDTH-1];
            r_next   = '0;
            cnt_next = CW'(NUM_WIDTH);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                if (!sub[DEN_WIDTH+1]) begin
                    r_next = sub[DEN_WIDTH:0];
                    q_next = {q_reg[NUM_WIDTH-2:0], 1'b1};
                end else begin
                    r_next = trial;
                    q_next = {q_reg[NUM_WIDTH-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CW'(1);
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg) begin
                    if (big && !(q_reg == NUM_WIDTH'(TMAX) + NUM_WIDTH'(1)))
                        quo_next = TMIN;
                    else
                        quo_next = T_WIDTH'(-q_reg);
                end else begin
                    quo_next = big ? TMAX : T_WIDTH'(q_reg);
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
        neg_reg <= neg_next; quo_reg <= quo_next;
    end
endmodule
`default_nettype wire

>>> design/rbnp_dp.sv
// Datapath: ray registers, box buffer, slab interval and nearest-hit state
`default_nettype none
module rbnp_dp #(
    parameter int COORD_WIDTH = rbnp_pkg::COORD_WIDTH_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_valid,
    input  wire [rbnp_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire [rbnp_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    input  wire signed [COORD_WIDTH-1:0]      box_min_x,
    input  wire signed [COORD_WIDTH-1:0]      box_min_y,
    input  wire signed [COORD_WIDTH-1:0]      box_min_z,
    input  wire signed [COORD_WIDTH-1:0]      box_max_x,
    input  wire signed [COORD_WIDTH-1:0]      box_max_y,
    input  wire signed [COORD_WIDTH-1:0]      box_max_z,
    input  wire [rbnp_pkg::IDX_WIDTH-1:0]     box_index,
    input  rbnp_pkg::dp_cmd_t                 cmd,
    output rbnp_pkg::dp_status_t              status,
    output logic                              found,
    output logic [rbnp_pkg::IDX_WIDTH-1:0]    best_index,
    output logic [rbnp_pkg::DIST_WIDTH-1:0]   best_distance
);
    import rbnp_pkg::*;
    localparam int DW = COORD_WIDTH + 1;           // difference width
    localparam int NW = DW + FRAC_BITS + 1;        // numerator width
    localparam logic signed [T_WIDTH-1:0] TMAX = {1'b0, {(T_WIDTH-1){1'b1}}};
    localparam logic signed [T_WIDTH-1:0] TMIN = {1'b1, {(T_WIDTH-1){1'b0}}};

    logic signed [COORD_WIDTH-1:0] org_reg [3];
    logic signed [DIR_WIDTH-1:0]   dir_reg [3];
    logic signed [COORD_WIDTH-1:0] lo_reg [3];
    logic signed [COORD_WIDTH-1:0] hi_reg [3];
    logic [IDX_WIDTH-1:0]          idx_reg;
    logic signed [COORD_WIDTH-1:0] o_sel_reg, blo_sel_reg, bhi_sel_reg;
    logic signed [DIR_WIDTH-1:0]   d_sel_reg;
    logic signed [T_WIDTH-1:0]     t1_reg, tmin_reg, tmax_reg;
    logic                          rej_reg;
    logic signed [T_WIDTH-1:0]     near_reg;
    logic [IDX_WIDTH-1:0]          nidx_reg;
    logic                          any_reg;

    logic signed [DW-1:0] diff;
    logic signed [NW-1:0] numer;
    logic                 div_done;
    logic signed [T_WIDTH-1:0] q;
    logic signed [T_WIDTH-1:0] ta, tb, nmin, nmax, hit;

    // numerator (bound - origin) << 16, divisor direction
    always_comb begin
        diff = cmd.side_hi ? (DW'(bhi_sel_reg) - DW'(o_sel_reg))
                           : (DW'(blo_sel_reg) - DW'(o_sel_reg));
        numer = NW'(diff) <<< FRAC_BITS;
    end

    rbnp_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DIR_WIDTH)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .num(numer), .den(d_sel_reg), .done(div_done), .quo(q)
    );

    always_comb begin
        ta = (t1_reg > q) ? q : t1_reg;
        tb = (t1_reg > q) ? t1_reg : q;
        nmin = (ta > tmin_reg) ? ta : tmin_reg;
        nmax = (tb < tmax_reg) ? tb : tmax_reg;
        hit  = (tmin_reg >= 0) ? tmin_reg : tmax_reg;
    end

    assign status.dir_zero = (d_sel_reg == '0);
    assign status.div_done = div_done;
    assign status.reject   = rej_reg;
    assign found         = any_reg;
    assign best_index    = any_reg ? nidx_reg : '0;
    assign best_distance = any_reg ? near_reg[DIST_WIDTH-1:0] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_reg[0] <= '0; org_reg[1] <= '0; org_reg[2] <= '0;
            dir_reg[0] <= DIR_WIDTH'(65536); dir_reg[1] <= '0; dir_reg[2] <= '0;
            near_reg <= TMAX; nidx_reg <= '0; any_reg <= 1'b0;
            rej_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_ORIGIN_X: org_reg[0] <= COORD_WIDTH'(cfg_data);
                    REG_ORIGIN_Y: org_reg[1] <= COORD_WIDTH'(cfg_data);
                    REG_ORIGIN_Z: org_reg[2] <= COORD_WIDTH'(cfg_data);
                    REG_DIR_X:    dir_reg[0] <= cfg_data[DIR_WIDTH-1:0];
                    REG_DIR_Y:    dir_reg[1] <= cfg_data[DIR_WIDTH-1:0];
                    REG_DIR_Z:    dir_reg[2] <= cfg_data[DIR_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (cmd.load_box) begin
                rej_reg <= 1'b0;
                tmin_reg <= TMIN;
                tmax_reg <= TMAX;
            end
            if (cmd.axis_merge && !rej_reg) begin
                if (d_sel_reg == '0) begin
                    if (o_sel_reg < blo_sel_reg || o_sel_reg > bhi_sel_reg)
                        rej_reg <= 1'b1;
                end else begin
                    tmin_reg <= nmin;
                    tmax_reg <= nmax;
                    if (nmin > nmax) rej_reg <= 1'b1;
                end
            end
            if (cmd.finish_box && !rej_reg && tmax_reg >= 0 && hit < near_reg) begin
                near_reg <= hit;
                nidx_reg <= idx_reg;
                any_reg  <= 1'b1;
            end
            if (cmd.clear_best) begin
                near_reg <= TMAX; nidx_reg <= '0; any_reg <= 1'b0;
            end
        end
        if (cmd.load_box) begin
            lo_reg[0] <= box_min_x; lo_reg[1] <= box_min_y; lo_reg[2] <= box_min_z;
            hi_reg[0] <= box_max_x; hi_reg[1] <= box_max_y; hi_reg[2] <= box_max_z;
            idx_reg <= box_index;
        end
        if (cmd.axis_setup) begin
            o_sel_reg   <= org_reg[cmd.axis];
            d_sel_reg   <= dir_reg[cmd.axis];
            blo_sel_reg <= lo_reg[cmd.axis];
            bhi_sel_reg <= hi_reg[cmd.axis];
        end
        if (div_done && !cmd.side_hi) t1_reg <= q;
    end
endmodule
`default_nettype wire

>>> design/ray_box_nearest_pick_top.sv
// Boxes are processed one at a time: a new box is taken only once the last one is done.
// All divisions of every axis go through the one shared divider.
// An axis whose direction is zero skips both divisions.
// Result request held in a register until taken; next box accepted after that.
// Reset (aresetn low, synchronous): ray origin 0, direction +x, nearest hit cleared.
// Top level: ray box nearest pick
`default_nettype none
module ray_box_nearest_pick_top #(
    parameter int COORD_WIDTH = rbnp_pkg::COORD_WIDTH_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // configuration write requests
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [rbnp_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire [rbnp_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
    // box requests
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire signed [COORD_WIDTH-1:0]       s_box_min_x,
    input  wire signed [COORD_WIDTH-1:0]       s_box_min_y,
    input  wire signed [COORD_WIDTH-1:0]       s_box_min_z,
    input  wire signed [COORD_WIDTH-1:0]       s_box_max_x,
    input  wire signed [COORD_WIDTH-1:0]       s_box_max_y,
    input  wire signed [COORD_WIDTH-1:0]       s_box_max_z,
    input  wire [rbnp_pkg::IDX_WIDTH-1:0]      s_box_index,
    input  wire                                s_last_box,
    // result requests
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic                               m_found,
    output logic [rbnp_pkg::IDX_WIDTH-1:0]     m_best_index,
    output logic [rbnp_pkg::DIST_WIDTH-1:0]    m_best_distance
);
    import rbnp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // config requests taken only while idle, so a box in flight never sees a new ray
    assign cfg_ready = s_ready;

    rbnp_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .last_in(s_last_box),
        .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .status(status)
    );

    rbnp_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .box_min_x(s_box_min_x), .box_min_y(s_box_min_y), .box_min_z(s_box_min_z),
        .box_max_x(s_box_max_x), .box_max_y(s_box_max_y), .box_max_z(s_box_max_z),
        .box_index(s_box_index),
        .cmd(cmd), .status(status),
        .found(m_found), .best_index(m_best_index), .best_distance(m_best_distance)
    );
endmodule
`default_nettype wire

>>> design/rbnp_checker.sv
// Checker: port-level assertions bound to the top level
`default_nettype none
`include "ray_box_nearest_pick_top_assert.svh"
module rbnp_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire        s_last_box,
    input wire        m_valid,
    input wire        m_ready,
    input wire        m_found,
    input wire [9:0]  m_best_index,
    input wire [30:0] m_best_distance
);
    // never takes a box while a result waits
    `RBNP_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_valid, !s_ready)
    // empty result carries zero fields
    `RBNP_ASSERT_IMP(a_empty_zero, aclk, aresetn, m_valid && !m_found,
        m_best_index == 10'd0 && m_best_distance == 31'd0)
    // a result holds until taken
    `RBNP_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_best_distance) && $stable(m_found))
    // a box not marked last produces no result next cycle
    `RBNP_ASSERT_NEXT(a_no_early, aclk, aresetn, s_valid && s_ready && !s_last_box,
        !m_valid)
endmodule
bind ray_box_nearest_pick_top rbnp_checker u_rbnp_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_last_box(s_last_box), .m_valid(m_valid), .m_ready(m_ready),
    .m_found(m_found), .m_best_index(m_best_index), .m_best_distance(m_best_distance)
);
`default_nettype wire
